// ===== hw/rtl/fktd_pkg.sv =====
// Shared types and constants for the four-key timed debouncer.
`default_nettype none

package fktd_pkg;

  localparam int unsigned OUT_KEYS    = 4;
  localparam int unsigned RAW_W       = 4;
  localparam int unsigned NOW_W       = 32;
  localparam int unsigned DEB_W       = 16;
  localparam int unsigned COLOR_W     = 24;

  localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 16'd20;
  localparam logic [COLOR_W-1:0] COLOR_RST    = 24'd3276950;

  typedef enum logic [1:0] {
    OP_SAMPLE        = 2'd0,
    OP_READ_PRESSED  = 2'd1,
    OP_READ_RELEASED = 2'd2,
    OP_NOP           = 2'd3
  } opcode_t;

  typedef enum logic {
    CFG_DEBOUNCE = 1'b0,
    CFG_COLOR    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [DEB_W-1:0]   debounce;
    logic [COLOR_W-1:0] color;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0]                  latch;
    logic [OUT_KEYS-1:0][COLOR_W-1:0]  color;
    logic [OUT_KEYS-1:0]               changed;
    logic                              show;
    logic [OUT_KEYS-1:0]               debounced;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/four_key_timed_debouncer_core.sv =====
// Top level of the four-key timed debouncer: stream ports, config and pipeline.
//
//  channel   dir  handshake          payload
//  in_       in   tvalid / tready    tuser: opcode; tdata: raw_keys, now_ms
//  out_      out  tvalid / tready    tdata: debounced, show, changed, colours, latch
//  cfg_      in   we                 index, wdata
//
// One beat per cycle sustained while the output is not stalled; a result passes
// through the input register, then the result register. Reset is synchronous, active
// low, clears levels, timers and latches and restores the config defaults. A stalled
// output holds its beat while the input register still takes one more; the input
// side stalls only when both are full.
`default_nettype none

module four_key_timed_debouncer_core #(
  parameter int KEY_COUNT = 4,
  parameter int TIME_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [1:0]   in_tuser,   // [1:0] opcode
  input  wire logic [39:0]  in_tdata,   // [3:0] raw_keys, [35:4] now_ms, [39:36] zero
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [111:0]      out_tdata,  // [3:0] debounced_keys, [4] pixels_show,
                                        // [8:5] changed_keys, [32:9] color_key_zero,
                                        // [56:33] color_key_one, [80:57] color_key_two,
                                        // [104:81] color_key_three, [108:105] latch_value,
                                        // [111:109] zero
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [23:0]  cfg_wdata
);

  fktd_pkg::cfg_t                       cfg_r;
  logic                                 s1_valid_r;
  fktd_pkg::opcode_t                    s1_op_r;
  logic [fktd_pkg::RAW_W-1:0]           s1_raw_r;
  logic [fktd_pkg::NOW_W-1:0]           s1_now_r;
  logic                                 out_valid_r;
  fktd_pkg::result_t                    out_res_r;
  fktd_pkg::result_t                    res;
  logic                                 s1_adv;
  logic                                 in_acc;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= fktd_pkg::DEBOUNCE_RST;
      cfg_r.color    <= fktd_pkg::COLOR_RST;
    end else if (cfg_we) begin
      unique case (fktd_pkg::cfg_idx_t'(cfg_index))
        fktd_pkg::CFG_DEBOUNCE: cfg_r.debounce <= cfg_wdata[fktd_pkg::DEB_W-1:0];
        fktd_pkg::CFG_COLOR:    cfg_r.color    <= cfg_wdata;
        default:                cfg_r          <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= fktd_pkg::opcode_t'(in_tuser);
      s1_raw_r <= in_tdata[3:0];
      s1_now_r <= in_tdata[35:4];
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  fktd_keys #(
    .KEY_COUNT (KEY_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_keys (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .op    (s1_op_r),
    .raw   (s1_raw_r),
    .now   (s1_now_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

endmodule

`default_nettype wire

// ===== hw/rtl/fktd_keys.sv =====
// Per-key debounce timers, stable levels, sticky latches and result forming.
`default_nettype none

module fktd_keys #(
  parameter int KEY_COUNT = 4,
  parameter int TIME_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire fktd_pkg::opcode_t             op,
  input  wire logic [fktd_pkg::RAW_W-1:0]    raw,
  input  wire logic [fktd_pkg::NOW_W-1:0]    now,
  input  wire fktd_pkg::cfg_t                cfg,
  output fktd_pkg::result_t                  res
);

  logic [KEY_COUNT-1:0]                 stable_r, stable_nxt;
  logic [KEY_COUNT-1:0]                 pressed_latch_r, pressed_latch_nxt;
  logic [KEY_COUNT-1:0]                 released_latch_r, released_latch_nxt;
  logic [KEY_COUNT-1:0][TIME_BITS-1:0]  timer_r, timer_nxt;
  logic [KEY_COUNT-1:0]                 raw_k;
  logic [KEY_COUNT-1:0]                 flip;
  logic [TIME_BITS-1:0]                 now_t;
  logic [TIME_BITS-1:0]                 deb_t;
  logic                                 sample;
  logic [fktd_pkg::RAW_W-1:0]           latch_val;

  assign now_t  = TIME_BITS'(now);
  assign deb_t  = TIME_BITS'(cfg.debounce);
  assign sample = step && (op == fktd_pkg::OP_SAMPLE);

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_raw
    if (k < fktd_pkg::RAW_W) begin : g_in
      assign raw_k[k] = raw[k];
    end else begin : g_zero
      assign raw_k[k] = 1'b0;
    end
  end

  always_comb begin
    logic [TIME_BITS-1:0] elapsed;
    logic                 diff;
    flip      = '0;
    timer_nxt = timer_r;
    elapsed   = '0;
    diff      = 1'b0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      diff    = raw_k[k] ^ stable_r[k];
      elapsed = now_t - timer_r[k];
      if (!diff) begin
        timer_nxt[k] = '0;
      end else if (timer_r[k] == '0) begin
        timer_nxt[k] = now_t;
      end else begin
        flip[k] = (elapsed >= deb_t);
      end
    end
    if (!sample) begin
      flip      = '0;
      timer_nxt = timer_r;
    end
  end

  assign stable_nxt = stable_r ^ flip;

  always_comb begin
    pressed_latch_nxt  = pressed_latch_r | (flip & raw_k);
    released_latch_nxt = released_latch_r | (flip & ~raw_k);
    latch_val          = '0;
    if (step) begin
      unique case (op)
        fktd_pkg::OP_READ_PRESSED: begin
          latch_val         = fktd_pkg::RAW_W'(pressed_latch_r);
          pressed_latch_nxt = '0;
        end
        fktd_pkg::OP_READ_RELEASED: begin
          latch_val          = fktd_pkg::RAW_W'(released_latch_r);
          released_latch_nxt = '0;
        end
        fktd_pkg::OP_SAMPLE, fktd_pkg::OP_NOP: begin
          latch_val = '0;
        end
        default: begin
          latch_val = '0;
        end
      endcase
    end
  end

  assign res.latch = latch_val;

  for (genvar j = 0; j < fktd_pkg::OUT_KEYS; j++) begin : g_out
    if (j < KEY_COUNT) begin : g_key
      assign res.debounced[j] = stable_nxt[j];
      assign res.changed[j]   = flip[j];
      assign res.color[j]     = (flip[j] && stable_nxt[j]) ? cfg.color : '0;
    end else begin : g_none
      assign res.debounced[j] = 1'b0;
      assign res.changed[j]   = 1'b0;
      assign res.color[j]     = '0;
    end
  end

  assign res.show = |flip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r         <= '0;
      pressed_latch_r  <= '0;
      released_latch_r <= '0;
      timer_r          <= '0;
    end else begin
      stable_r         <= stable_nxt;
      pressed_latch_r  <= pressed_latch_nxt;
      released_latch_r <= released_latch_nxt;
      timer_r          <= timer_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_levels_hold_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op != fktd_pkg::OP_SAMPLE) |=> $stable(stable_r))
    else $error("debounced levels moved on a non-sample beat");

  a_pressed_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op == fktd_pkg::OP_READ_PRESSED) |=> (pressed_latch_r == '0))
    else $error("pressed latch not cleared by read");

  a_released_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && op == fktd_pkg::OP_READ_RELEASED) |=> (released_latch_r == '0))
    else $error("released latch not cleared by read");

  a_flip_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (|flip) |=> (((pressed_latch_r | released_latch_r) & $past(flip)) == $past(flip)))
    else $error("key flip not recorded in a latch");
`endif

endmodule

`default_nettype wire
